// ===== rtl/pdq_pkg.sv =====
// Shared types, constants and palette helpers for the palette dither quantizer.
// Used by the front end, the back end and the top level; depends on nothing else.
package pdq_pkg;

  localparam int unsigned MaxColumnsDef = 128;
  localparam int unsigned InQueueDepth  = 2;
  localparam int unsigned OutQueueDepth = 2;
  localparam logic [17:0] RecipHundred  = 18'd167773;

  typedef enum logic [2:0] {
    REG_MAX_SAMPLE  = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_CONTRAST    = 3'd2,
    REG_LUMA_WEIGHT = 3'd3,
    REG_DITHER_DIV  = 3'd4,
    REG_COLORS_EN   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_GO,
    ST_SCALE_WAIT,
    ST_MUL,
    ST_ADJ,
    ST_LUMA,
    ST_CHROMA,
    ST_SEARCH,
    ST_DIFF_GO,
    ST_DIFF_WAIT,
    ST_WRITE
  } back_state_e;

  typedef struct packed {
    logic [7:0]        max_sample;
    logic signed [8:0] brightness;
    logic signed [8:0] contrast;
    logic [4:0]        luma_weight;
    logic [7:0]        dither_div;
    logic [15:0]       colors_en;
  } cfg_t;

  typedef struct packed {
    logic frame_start;
    logic first_row;
    logic last;
  } pix_flags_t;

  // Palette colors, blue in bits 23:16, green in 15:8, red in 7:0.
  localparam logic [23:0] PalRgb [16] = '{
    24'h000000, 24'hf0f0f0, 24'h2000d0, 24'hd0f000,
    24'hd000f0, 24'h00f000, 24'hd00000, 24'h00e0e0,
    24'h0060e0, 24'ha0c0e0, 24'hc0c0f0, 24'hf0f0c0,
    24'hf0c0f0, 24'hc0f0c0, 24'hf0c0c0, 24'hc0f0f0
  };

  // Returns {v, u, y} of one color; only evaluated on constants.
  function automatic logic [23:0] yuv_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int n;
    int y;
    int db;
    int dr;
    int u;
    int v;
    n  = 30 * int'(r) + 59 * int'(g) + 11 * int'(b);
    y  = (n * 5243) >>> 19;
    db = int'(b) - y;
    dr = int'(r) - y;
    u  = (db < 0) ? -(((-db) * 1479) >>> 12) : ((db * 1479) >>> 12);
    v  = (dr < 0) ? -(((-dr) * 2631) >>> 12) : ((dr * 2631) >>> 12);
    u  = u + 128;
    v  = v + 128;
    return {v[7:0], u[7:0], y[7:0]};
  endfunction

endpackage

// ===== rtl/pdq_fifo.sv =====
// Small register queue used between the front and back and at the output.
// Depends on nothing but its parameters.
module pdq_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/pdq_div.sv =====
// Bit-serial unsigned divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
// Depends on nothing else.
module pdq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic        busy_o,
  output logic [15:0] quotient_o
);
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  dsr_q;
  logic [15:0] quo_q;
  logic [8:0]  rem_sh;
  logic        ge;

  assign rem_sh     = {rem_q, quo_q[15]};
  assign ge         = (rem_sh >= {1'b0, dsr_q});
  assign rem_d      = ge ? 8'(rem_sh - {1'b0, dsr_q}) : rem_sh[7:0];
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 5'd16;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != 5'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[14:0], ge};
    end
  end

endmodule

// ===== rtl/pdq_front.sv =====
// Front end: tracks column and first row and classifies each accepted pixel.
// Depends on pdq_pkg.
module pdq_front #(
  parameter int unsigned MAX_COLUMNS = pdq_pkg::MaxColumnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           frame_start_i,
  input  logic                           row_end_i,
  output logic [$clog2(MAX_COLUMNS)-1:0] col_o,
  output pdq_pkg::pix_flags_t            flags_o
);
  import pdq_pkg::*;
  localparam int unsigned ColW = $clog2(MAX_COLUMNS);

  logic [ColW-1:0] col_q, col_d;
  logic            first_row_q, first_row_d;

  always_comb begin
    col_o               = frame_start_i ? '0 : col_q;
    flags_o.frame_start = frame_start_i;
    flags_o.first_row   = frame_start_i || first_row_q;
    flags_o.last        = row_end_i || (col_o == ColW'(MAX_COLUMNS - 1));
    col_d               = col_q;
    first_row_d         = first_row_q;
    if (accept_i) begin
      col_d       = flags_o.last ? '0 : col_o + 1'b1;
      first_row_d = flags_o.last ? 1'b0 : flags_o.first_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

endmodule

// ===== rtl/pdq_back.sv =====
// Back end: sequencer that adjusts, dithers and palette-matches one pixel at a time.
// Depends on pdq_pkg and on three pdq_div lanes wired in the top level.
module pdq_back #(
  parameter int unsigned MAX_COLUMNS = pdq_pkg::MaxColumnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pdq_pkg::cfg_t                  cfg_i,
  input  logic                           in_empty_i,
  output logic                           in_pop_o,
  input  logic [23:0]                    in_rgb_i,
  input  logic [$clog2(MAX_COLUMNS)-1:0] in_col_i,
  input  pdq_pkg::pix_flags_t            in_flags_i,
  output logic                           div_start_o,
  output logic [2:0][15:0]               div_dvd_o,
  output logic [7:0]                     div_dsr_o,
  input  logic                           div_busy_i,
  input  logic [2:0][15:0]               div_quo_i,
  input  logic                           out_full_i,
  output logic                           out_push_o,
  output logic [3:0]                     out_index_o
);
  import pdq_pkg::*;
  localparam int unsigned ColW = $clog2(MAX_COLUMNS);

  back_state_e state_q, state_d;

  logic [23:0]       mem_q [MAX_COLUMNS];
  logic [23:0]       below_q;
  logic [23:0]       right_q, right_d;
  logic [23:0]       rgb_q;
  logic [ColW-1:0]   col_q;
  pix_flags_t        flags_q;
  logic [2:0][7:0]   sc_q;
  logic signed [21:0] prod_q [3];
  logic [2:0][7:0]   chan_q;
  logic [7:0]        y_q, u_q, v_q;
  logic [1:0]        grp_q;
  logic [3:0]        best_q;
  logic [14:0]       best_err_q;

  logic [23:0]       pal_yuv [16];
  logic [23:0]       right_eff;
  logic [23:0]       packed_d;
  logic              full_scale;
  logic              mem_we;

  logic signed [10:0] adj_t [3];
  logic signed [10:0] adj_g;
  logic signed [21:0] prod_d [3];
  logic [21:0]        pmag [3];
  logic [35:0]        pq [3];
  logic signed [12:0] ps [3];
  logic [7:0]         cl [3];
  logic signed [9:0]  ab [3];
  logic [7:0]         ab8 [3];
  logic signed [9:0]  ar [3];
  logic [7:0]         chan_d [3];
  logic [7:0]         qch [3];
  logic [14:0]        luma_n;
  logic [27:0]        luma_m;
  logic signed [9:0]  db, dr;
  logic [8:0]         dbm, drm;
  logic [19:0]        um, vm;
  logic [7:0]         u_d, v_d;
  logic signed [9:0]  ediff [3];
  logic [7:0]         emag [3];
  logic [7:0]         half [3];
  logic [7:0]         dl [3];
  logic [14:0]        run_err;
  logic [3:0]         run_idx;
  logic [3:0]         sidx [4];
  logic [23:0]        sp [4];
  logic [8:0]         dy [4];
  logic [8:0]         du [4];
  logic [8:0]         dv [4];
  logic [14:0]        serr [4];

  for (genvar i = 0; i < 16; i++) begin : g_pal
    localparam logic [23:0] Yuv = yuv_of(PalRgb[i][7:0], PalRgb[i][15:8], PalRgb[i][23:16]);
    assign pal_yuv[i] = Yuv;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:       if (!in_empty_i) state_d = ST_SCALE_GO;
      ST_SCALE_GO:   state_d = ST_SCALE_WAIT;
      ST_SCALE_WAIT: if (!div_busy_i) state_d = ST_MUL;
      ST_MUL:        state_d = ST_ADJ;
      ST_ADJ:        state_d = ST_LUMA;
      ST_LUMA:       state_d = ST_CHROMA;
      ST_CHROMA:     state_d = ST_SEARCH;
      ST_SEARCH:     if (grp_q == 2'd3) state_d = ST_DIFF_GO;
      ST_DIFF_GO:    state_d = ST_DIFF_WAIT;
      ST_DIFF_WAIT:  if (!div_busy_i) state_d = ST_WRITE;
      ST_WRITE:      if (!out_full_i) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_pop_o    = (state_q == ST_IDLE) && !in_empty_i;
    div_start_o = (state_q == ST_SCALE_GO) || (state_q == ST_DIFF_GO);
    out_push_o  = (state_q == ST_WRITE) && !out_full_i;
    mem_we      = out_push_o;
  end

  assign full_scale  = (cfg_i.max_sample == 8'd0) || (cfg_i.max_sample == 8'd255);
  assign right_eff   = flags_q.frame_start ? '0 : right_q;
  assign out_index_o = best_q;
  assign adj_g       = 11'sd100 + {{2{cfg_i.contrast[8]}}, cfg_i.contrast};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      adj_t[ch]  = $signed({3'b000, sc_q[ch]})
                   + $signed({{2{cfg_i.brightness[8]}}, cfg_i.brightness}) - 11'sd128;
      prod_d[ch] = 22'(adj_t[ch]) * 22'(adj_g);
      pmag[ch]   = prod_q[ch][21] ? 22'(-prod_q[ch]) : 22'(prod_q[ch]);
      pq[ch]     = 36'(pmag[ch][17:0]) * 36'(RecipHundred);
      ps[ch]     = prod_q[ch][21] ? -$signed({2'b00, pq[ch][34:24]})
                                  : $signed({2'b00, pq[ch][34:24]});
      ps[ch]     = ps[ch] + 13'sd128;
      if (ps[ch] < 0) begin
        cl[ch] = 8'd0;
      end else if (ps[ch] > 13'sd255) begin
        cl[ch] = 8'd255;
      end else begin
        cl[ch] = ps[ch][7:0];
      end
      ab[ch]  = $signed({2'b00, cl[ch]}) + $signed({{2{below_q[8*ch+7]}}, below_q[8*ch +: 8]});
      ab8[ch] = cl[ch];
      if (!flags_q.first_row && (ab[ch] >= 0) && (ab[ch] <= 10'sd255)) begin
        ab8[ch] = ab[ch][7:0];
      end
      ar[ch]  = $signed({2'b00, ab8[ch]})
                + $signed({{2{right_eff[8*ch+7]}}, right_eff[8*ch +: 8]});
      chan_d[ch] = ((ar[ch] >= 0) && (ar[ch] <= 10'sd255)) ? ar[ch][7:0] : ab8[ch];
      qch[ch]    = {chan_q[ch][7:4], 4'b0000};
    end
  end

  always_comb begin
    luma_n = 15'(qch[0]) * 15'd30 + 15'(qch[1]) * 15'd59 + 15'(qch[2]) * 15'd11;
    luma_m = 28'(luma_n) * 28'd5243;
    db     = $signed({2'b00, qch[2]}) - $signed({2'b00, y_q});
    dr     = $signed({2'b00, qch[0]}) - $signed({2'b00, y_q});
    dbm    = db[9] ? 9'(-db) : 9'(db);
    drm    = dr[9] ? 9'(-dr) : 9'(dr);
    um     = 20'(dbm) * 20'd1479;
    vm     = 20'(drm) * 20'd2631;
    u_d    = (db[9] ? 8'(8'd0 - um[19:12]) : um[19:12]) + 8'd128;
    v_d    = (dr[9] ? 8'(8'd0 - vm[19:12]) : vm[19:12]) + 8'd128;
  end

  always_comb begin
    run_err = best_err_q;
    run_idx = best_q;
    for (int k = 0; k < 4; k++) begin
      sidx[k] = {grp_q, 2'(k)};
      sp[k]   = pal_yuv[sidx[k]];
      dy[k]   = (y_q >= sp[k][7:0])   ? 9'(y_q - sp[k][7:0])   : 9'(sp[k][7:0] - y_q);
      du[k]   = (u_q >= sp[k][15:8])  ? 9'(u_q - sp[k][15:8])  : 9'(sp[k][15:8] - u_q);
      dv[k]   = (v_q >= sp[k][23:16]) ? 9'(v_q - sp[k][23:16]) : 9'(sp[k][23:16] - v_q);
      serr[k] = 15'(cfg_i.luma_weight) * 15'(dy[k]) + 15'(du[k]) * 15'd3 + 15'(dv[k]) * 15'd3;
      if (cfg_i.colors_en[sidx[k]] && (serr[k] < run_err)) begin
        run_err = serr[k];
        run_idx = sidx[k];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      ediff[ch] = $signed({2'b00, chan_q[ch]}) - $signed({2'b00, PalRgb[best_q][8*ch +: 8]});
      emag[ch]  = ediff[ch][9] ? 8'(-ediff[ch]) : 8'(ediff[ch]);
      half[ch]  = {1'b0, div_quo_i[ch][7:1]};
      dl[ch]    = ediff[ch][9] ? 8'(8'd0 - half[ch]) : half[ch];
      if (state_q == ST_SCALE_GO) begin
        div_dvd_o[ch] = {rgb_q[8*ch +: 8], 8'd0} - {8'd0, rgb_q[8*ch +: 8]};
      end else begin
        div_dvd_o[ch] = {8'd0, emag[ch]};
      end
    end
    div_dsr_o = (state_q == ST_SCALE_GO) ? cfg_i.max_sample : cfg_i.dither_div;
    packed_d  = (!flags_q.last && (cfg_i.dither_div != 8'd0)) ? {dl[2], dl[1], dl[0]} : '0;
    right_d   = out_push_o ? packed_d : right_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      right_q <= '0;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      right_q <= right_d;
      if (state_q == ST_CHROMA) begin
        grp_q <= '0;
      end else if (state_q == ST_SEARCH) begin
        grp_q <= grp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_pop_o) begin
      rgb_q   <= in_rgb_i;
      col_q   <= in_col_i;
      flags_q <= in_flags_i;
      below_q <= mem_q[in_col_i];
    end
    if (mem_we) begin
      mem_q[col_q] <= packed_d;
    end
    if ((state_q == ST_SCALE_WAIT) && !div_busy_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        sc_q[ch] <= full_scale ? rgb_q[8*ch +: 8] : div_quo_i[ch][7:0];
      end
    end
    if (state_q == ST_MUL) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= prod_d[ch];
      end
    end
    if (state_q == ST_ADJ) begin
      for (int ch = 0; ch < 3; ch++) begin
        chan_q[ch] <= chan_d[ch];
      end
    end
    if (state_q == ST_LUMA) begin
      y_q <= luma_m[26:19];
    end
    if (state_q == ST_CHROMA) begin
      u_q        <= u_d;
      v_q        <= v_d;
      best_q     <= '0;
      best_err_q <= '1;
    end
    if (state_q == ST_SEARCH) begin
      best_q     <= run_idx;
      best_err_q <= run_err;
    end
  end

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start_o |-> !div_busy_i)
    else $error("divider started while busy");

  a_write_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after a result transfer");

  a_search_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SEARCH) && (grp_q == 2'd3)) |=> (state_q == ST_DIFF_GO))
    else $error("palette search did not end after four groups");

endmodule

// ===== rtl/palette_dither_quantizer_top.sv =====
// Top level of the palette dither quantizer: configuration registers, front end,
// queues, back-end sequencer and three divider lanes. Depends on all the other files.
//
// Pixels enter in raster order through a queue-style port: an input transfer
// happens when push is high and full is low. Results leave the same way: the
// oldest palette index is shown while empty is low and is taken when pop is high.
// Configuration writes land on the next clock edge when cfg_we_i is high.
// The front end classifies each pixel (column, first row, end of row) on entry
// and queues it; the back end then handles one pixel at a time and takes the
// next one only after writing out its result. Most of its time goes into two
// divider waits (rescale and error division, 16 steps each) and a palette
// search over four groups of four colors.
// Reset empties both queues, restores the register defaults, clears the
// pending right-hand error and starts in the first row at column 0.
// When the receiver stalls the back end holds its finished result until the
// output queue has room, and the input queue fills and raises full.
module palette_dither_quantizer_top #(
  parameter int unsigned MAX_COLUMNS = pdq_pkg::MaxColumnsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        frame_start_i,
  input  logic        row_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  palette_index_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import pdq_pkg::*;
  localparam int unsigned ColW = $clog2(MAX_COLUMNS);
  localparam int unsigned FlW  = $bits(pix_flags_t);
  localparam int unsigned QW   = 24 + FlW + ColW;

  cfg_t            cfg_q;
  logic [ColW-1:0] f_col;
  pix_flags_t      f_flags;
  logic            in_accept;
  logic [QW-1:0]   q_in_data, q_out_data;
  logic            q_empty, q_pop;
  logic            div_start, div_busy;
  logic [2:0]      lane_busy;
  logic [2:0][15:0] div_dvd, div_quo;
  logic [7:0]      div_dsr;
  logic            o_full, o_push;
  logic [3:0]      o_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_sample  <= 8'd255;
      cfg_q.brightness  <= '0;
      cfg_q.contrast    <= '0;
      cfg_q.luma_weight <= 5'd7;
      cfg_q.dither_div  <= 8'd1;
      cfg_q.colors_en   <= 16'h03ff;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_SAMPLE:  cfg_q.max_sample  <= cfg_wdata_i[7:0];
        REG_BRIGHTNESS:  cfg_q.brightness  <= $signed(cfg_wdata_i[8:0]);
        REG_CONTRAST:    cfg_q.contrast    <= $signed(cfg_wdata_i[8:0]);
        REG_LUMA_WEIGHT: cfg_q.luma_weight <= cfg_wdata_i[4:0];
        REG_DITHER_DIV:  cfg_q.dither_div  <= cfg_wdata_i[7:0];
        REG_COLORS_EN:   cfg_q.colors_en   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_accept = push && !full;
  assign q_in_data = {blue_i, green_i, red_i, f_flags, f_col};

  pdq_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (in_accept),
    .frame_start_i,
    .row_end_i,
    .col_o         (f_col),
    .flags_o       (f_flags)
  );

  pdq_fifo #(.W(QW), .DEPTH(InQueueDepth)) u_in_q (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (q_in_data),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out_data),
    .empty_o (q_empty)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    pdq_div u_div (
      .clk_i,
      .rst_ni,
      .start_i    (div_start),
      .dividend_i (div_dvd[ch]),
      .divisor_i  (div_dsr),
      .busy_o     (lane_busy[ch]),
      .quotient_o (div_quo[ch])
    );
  end
  assign div_busy = |lane_busy;

  pdq_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .in_empty_i  (q_empty),
    .in_pop_o    (q_pop),
    .in_rgb_i    (q_out_data[QW-1 -: 24]),
    .in_col_i    (q_out_data[ColW-1:0]),
    .in_flags_i  (pix_flags_t'(q_out_data[ColW +: FlW])),
    .div_start_o (div_start),
    .div_dvd_o   (div_dvd),
    .div_dsr_o   (div_dsr),
    .div_busy_i  (div_busy),
    .div_quo_i   (div_quo),
    .out_full_i  (o_full),
    .out_push_o  (o_push),
    .out_index_o (o_index)
  );

  pdq_fifo #(.W(4), .DEPTH(OutQueueDepth)) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (o_push),
    .data_i  (o_index),
    .full_o  (o_full),
    .pop_i   (pop),
    .data_o  (palette_index_o),
    .empty_o (empty)
  );

endmodule
